// ===== design/plp_pkg.sv =====
// package for the peer liveness prober: sizes, codes, item structs
// no dependencies
`default_nettype none
package plp_pkg;
    localparam int NUM_PEERS = 16;
    localparam int PW = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_TICK = 3'd1;
    localparam logic [2:0] OP_PING = 3'd2;
    localparam logic [2:0] OP_PONG = 3'd3;
    localparam logic [2:0] OP_BYE = 3'd4;
    localparam logic [2:0] OP_AUDIO = 3'd5;
    localparam logic [2:0] OP_SHUT = 3'd6;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_PING = 2'd1;
    localparam logic [1:0] ACT_PONG = 2'd2;
    localparam logic [1:0] ACT_BYE = 2'd3;

    localparam logic [1:0] PR_UNKNOWN = 2'd0;
    localparam logic [1:0] PR_ONLINE = 2'd1;
    localparam logic [1:0] PR_OFFLINE = 2'd2;

    localparam logic [2:0] REG_SEED = 3'd0;
    localparam logic [2:0] REG_ON_MIN = 3'd1;
    localparam logic [2:0] REG_ON_MAX = 3'd2;
    localparam logic [2:0] REG_OFF_MIN = 3'd3;
    localparam logic [2:0] REG_OFF_MAX = 3'd4;
    localparam logic [2:0] REG_RETRY1 = 3'd5;
    localparam logic [2:0] REG_RETRY2 = 3'd6;
    localparam logic [2:0] REG_ATTEMPTS = 3'd7;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [5:0]  dest_peer;
        logic [47:0] now_ms;
        logic [63:0] packet_session;
        logic [63:0] packet_nonce;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  out_peer;
        logic [1:0]  action;
        logic [63:0] out_nonce;
        logic [1:0]  presence;
        logic [15:0] rtt_ms;
        logic        rtt_valid;
        logic [47:0] heard_at_ms;
        logic [63:0] remote_session;
        logic        last;
    } t_out_item;

    // one peer table entry
    typedef struct packed {
        logic [1:0]  presence;
        logic        awaiting;
        logic [2:0]  attempts;
        logic [63:0] nonce;
        logic [47:0] sent_at;
        logic [47:0] retry_at;
        logic [47:0] probe_at;
        logic [47:0] seen_at;
        logic [63:0] session;
        logic [15:0] rtt;
        logic        rtt_ok;
    } t_peer;

    localparam int PEER_BITS = $bits(t_peer);

    function automatic logic [47:0] add_sat(input logic [47:0] t, input logic [47:0] d);
        logic [48:0] s;
        s = {1'b0, t} + {1'b0, d};
        return s[48] ? MAX48 : s[47:0];
    endfunction

    function automatic logic [63:0] xs_next(input logic [63:0] s);
        logic [63:0] v;
        v = s ^ (s << 13);
        v = v ^ (v >> 7);
        v = v ^ (v << 17);
        return (v == 64'd0) ? 64'd1 : v;
    endfunction
endpackage
`default_nettype wire

// ===== design/plp_ram.sv =====
// generic single port ram with registered read
// no dependencies
`default_nettype none
module plp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== design/plp_modu.sv =====
// bit serial remainder unit: r mod span, one quotient bit a cycle
// depends on plp_pkg
`default_nettype none
module plp_modu (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [20:0] i_den,
    output logic             o_done,
    output logic [20:0]      o_rem
);
    import plp_pkg::*;
    logic [63:0] r_num;
    logic [21:0] r_rem;
    logic [20:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [21:0] w_sh;
    assign w_sh = {r_rem[20:0], r_num[63]};
    assign o_rem = r_rem[20:0];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt <= 7'd0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num <= i_num;
                r_den <= i_den;
                r_rem <= 22'd0;
                r_cnt <= 7'd0;
            end else if (r_busy) begin
                r_num <= {r_num[62:0], 1'b0};
                r_rem <= (w_sh >= {1'b0, r_den}) ? w_sh - {1'b0, r_den} : w_sh;
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== design/peer_liveness_prober.sv =====
// peer liveness prober top level: sequencer over the peer table memory
// depends on plp_pkg, plp_ram, plp_modu
//
// channel | dir | handshake            | payload
// in      | in  | i_in_valid/o_in_ready| t_in_item
// out     | out | o_out_valid/i_out_ready | t_out_item
// cfg     | in  | i_cfg_valid/o_cfg_ready | index 3, data 64
//
// a packet passes the read, wait, eval, write and out states; when a probe delay is drawn,
// a jit state and then a fin state, waiting on the remainder unit, come before write;
// a ping that re-arms the probe repeats the write state; a start walks all peers through
// the same states, a tick or shutdown only once started; a flush state releases the last result
// after reset a clearing pass writes every entry before items are taken
// a result held by a stalled output holds the walk; a new item waits for the last result
`default_nettype none
module peer_liveness_prober (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire plp_pkg::t_in_item i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output plp_pkg::t_out_item     o_out,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [63:0]       i_cfg_data
);
    import plp_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_WAIT, S_EVAL, S_JIT, S_FIN, S_WRITE, S_OUT, S_FLUSH
    } t_state;

    t_state      r_state;
    t_in_item    r_item;
    logic [PW-1:0] r_idx;
    logic        r_walk, r_started;
    logic [63:0] r_rng;
    logic [19:0] r_on_min, r_on_max, r_off_min, r_off_max;
    logic [15:0] r_retry1, r_retry2;
    logic [2:0]  r_max_att;
    t_peer       r_peer;
    logic        r_emit;
    logic [1:0]  r_act;
    logic [63:0] r_onc;
    logic        r_jit_on;
    logic [19:0] r_jlo;
    t_out_item   r_pend;
    logic        r_pend_v;

    logic          w_we;
    t_peer         w_rd, w_wd;
    logic [PW-1:0] w_addr;
    logic          w_mstart, w_mdone;
    logic [20:0]   w_rem, w_den;
    logic [63:0]   w_rnd;
    logic [19:0]   w_lo, w_hi;
    logic          w_is_last;

    assign w_addr = r_idx;
    assign w_wd = (r_state == S_CLEAR) ? '0 : r_peer;
    assign w_we = (r_state == S_CLEAR) || (r_state == S_WRITE);

    plp_ram #(.WIDTH(PEER_BITS), .DEPTH(NUM_PEERS)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_wd), .o_rdata(w_rd)
    );

    assign w_lo = r_jit_on ? r_on_min : r_off_min;
    assign w_hi = r_jit_on ? r_on_max : r_off_max;
    assign w_rnd = xs_next(r_rng);
    assign w_den = {1'b0, w_hi} - {1'b0, w_lo} + 21'd1;
    assign w_mstart = (r_state == S_JIT) && (w_hi >= w_lo);

    plp_modu u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_mstart), .i_num(w_rnd),
        .i_den(w_den), .o_done(w_mdone), .o_rem(w_rem)
    );

    assign o_in_ready = (r_state == S_IDLE) && !o_out_valid;
    assign o_cfg_ready = (r_state == S_IDLE) || (r_state == S_CLEAR);
    assign w_is_last = !r_walk || (r_idx == PW'(NUM_PEERS - 1));

    always_ff @(posedge i_clk) begin
        t_peer       p;
        logic        em, need_j, jon;
        logic [1:0]  act;
        logic [63:0] onc;
        logic [63:0] nn;
        logic [16:0] d;
        t_out_item   ob;
        logic        ov;
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx <= '0;
            r_started <= 1'b0;
            r_rng <= 64'd1;
            r_on_min <= 20'd25000;
            r_on_max <= 20'd35000;
            r_off_min <= 20'd60000;
            r_off_max <= 20'd120000;
            r_retry1 <= 16'd1000;
            r_retry2 <= 16'd2000;
            r_max_att <= 3'd3;
            o_out_valid <= 1'b0;
            r_walk <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            ov = o_out_valid && !i_out_ready;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_SEED:     r_rng <= (i_cfg_data == 64'd0) ? 64'd1 : i_cfg_data;
                    REG_ON_MIN:   r_on_min <= i_cfg_data[19:0];
                    REG_ON_MAX:   r_on_max <= i_cfg_data[19:0];
                    REG_OFF_MIN:  r_off_min <= i_cfg_data[19:0];
                    REG_OFF_MAX:  r_off_max <= i_cfg_data[19:0];
                    REG_RETRY1:   r_retry1 <= i_cfg_data[15:0];
                    REG_RETRY2:   r_retry2 <= i_cfg_data[15:0];
                    REG_ATTEMPTS: r_max_att <= i_cfg_data[2:0];
                    default:      r_max_att <= r_max_att;
                endcase
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_idx == PW'(NUM_PEERS - 1)) begin
                        r_state <= S_IDLE;
                        r_idx <= '0;
                    end else begin
                        r_idx <= r_idx + PW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_item <= i_in;
                        case (i_in.opcode)
                            OP_START: begin
                                r_started <= 1'b1;
                                r_walk <= 1'b1;
                                r_idx <= '0;
                                r_state <= S_READ;
                            end
                            OP_TICK, OP_SHUT: begin
                                r_walk <= 1'b1;
                                r_idx <= '0;
                                r_state <= r_started ? S_READ : S_IDLE;
                            end
                            OP_PING, OP_PONG, OP_BYE, OP_AUDIO: begin
                                r_walk <= 1'b0;
                                r_idx <= i_in.dest_peer[PW-1:0];
                                r_state <= (32'(i_in.dest_peer) < NUM_PEERS) ?
                                    S_READ : S_IDLE;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_READ: r_state <= S_WAIT;
                S_WAIT: r_state <= S_EVAL;
                S_EVAL: begin
                    p = w_rd;
                    em = 1'b0;
                    act = ACT_NONE;
                    onc = 64'd0;
                    need_j = 1'b0;
                    jon = 1'b0;
                    case (r_item.opcode)
                        OP_START: p.probe_at = r_item.now_ms;
                        OP_TICK: begin
                            if (p.awaiting) begin
                                if (r_item.now_ms >= p.retry_at) begin
                                    if (p.attempts >= r_max_att) begin
                                        p.awaiting = 1'b0;
                                        if (p.presence != PR_UNKNOWN) p.presence = PR_OFFLINE;
                                        p.rtt_ok = 1'b0;
                                        p.rtt = 16'd0;
                                        need_j = 1'b1;
                                    end else begin
                                        p.attempts = p.attempts + 3'd1;
                                        p.retry_at = add_sat(r_item.now_ms, {32'd0, r_retry2});
                                        em = 1'b1;
                                        act = ACT_PING;
                                        onc = p.nonce;
                                    end
                                end
                            end else if (r_item.now_ms >= p.probe_at) begin
                                nn = w_rnd;
                                r_rng <= nn;
                                p.awaiting = 1'b1;
                                p.nonce = nn;
                                p.sent_at = r_item.now_ms;
                                p.attempts = 3'd1;
                                p.retry_at = add_sat(r_item.now_ms, {32'd0, r_retry1});
                                em = 1'b1;
                                act = ACT_PING;
                                onc = nn;
                            end
                        end
                        OP_SHUT: begin
                            em = 1'b1;
                            act = ACT_BYE;
                        end
                        OP_PING: begin
                            if (p.session != r_item.packet_session) begin
                                p.rtt_ok = 1'b0;
                                p.rtt = 16'd0;
                            end
                            p.session = r_item.packet_session;
                            p.presence = PR_ONLINE;
                            p.seen_at = r_item.now_ms;
                            em = 1'b1;
                            act = ACT_PONG;
                            onc = r_item.packet_nonce;
                            if (!p.awaiting) begin
                                p.attempts = 3'd0;
                                p.nonce = 64'd0;
                                need_j = 1'b1;
                                jon = 1'b1;
                            end
                        end
                        OP_PONG: begin
                            em = 1'b1;
                            if (p.awaiting && r_item.packet_nonce == p.nonce) begin
                                p.session = r_item.packet_session;
                                if (r_item.now_ms >= p.sent_at) begin
                                    d = (r_item.now_ms - p.sent_at > 48'd65535) ? 17'h0FFFF
                                        : 17'(r_item.now_ms - p.sent_at);
                                    p.rtt = d[15:0];
                                    p.rtt_ok = 1'b1;
                                end else begin
                                    p.rtt = 16'd0;
                                    p.rtt_ok = 1'b0;
                                end
                                p.presence = PR_ONLINE;
                                p.seen_at = r_item.now_ms;
                                p.awaiting = 1'b0;
                                p.attempts = 3'd0;
                                p.nonce = 64'd0;
                                need_j = 1'b1;
                                jon = 1'b1;
                            end
                        end
                        OP_BYE: begin
                            em = 1'b1;
                            if (p.session != 64'd0 && p.session == r_item.packet_session) begin
                                p.awaiting = 1'b0;
                                p.presence = PR_OFFLINE;
                                p.rtt_ok = 1'b0;
                                p.rtt = 16'd0;
                                need_j = 1'b1;
                            end
                        end
                        OP_AUDIO: begin
                            em = 1'b1;
                            p.presence = PR_ONLINE;
                            p.seen_at = r_item.now_ms;
                            if (!p.awaiting) begin
                                p.attempts = 3'd0;
                                p.nonce = 64'd0;
                                need_j = 1'b1;
                                jon = 1'b1;
                            end
                        end
                        default: em = 1'b0;
                    endcase
                    r_peer <= p;
                    r_emit <= em;
                    r_act <= act;
                    r_onc <= onc;
                    r_jit_on <= jon;
                    r_state <= need_j ? S_JIT : S_WRITE;
                end
                S_JIT: begin
                    r_rng <= w_rnd;
                    r_jlo <= w_lo;
                    if (w_hi >= w_lo) begin
                        r_state <= S_FIN;
                    end else begin
                        r_peer.probe_at <= add_sat(r_item.now_ms, {28'd0, w_lo});
                        r_state <= S_WRITE;
                    end
                end
                S_FIN: begin
                    if (w_mdone) begin
                        r_peer.probe_at <= add_sat(r_item.now_ms,
                            {27'd0, {1'b0, r_jlo} + w_rem});
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (r_item.opcode == OP_PING && !r_peer.awaiting && !r_peer.rtt_ok) begin
                        r_peer.probe_at <= r_item.now_ms;
                        r_state <= S_WRITE;
                        r_item.opcode <= OP_AUDIO;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // a result is held back until the next one or the end shows whether it is last
                    if (!o_out_valid || i_out_ready) begin
                        if (r_emit) begin
                            if (r_pend_v) begin
                                o_out <= r_pend;
                                ov = 1'b1;
                            end
                            ob.out_peer = 6'(r_idx);
                            ob.action = r_act;
                            ob.out_nonce = r_onc;
                            ob.presence = r_peer.presence;
                            ob.rtt_ms = r_peer.rtt;
                            ob.rtt_valid = r_peer.rtt_ok;
                            ob.heard_at_ms = r_peer.seen_at;
                            ob.remote_session = r_peer.session;
                            ob.last = 1'b0;
                            r_pend <= ob;
                            r_pend_v <= 1'b1;
                        end
                        if (w_is_last) begin
                            if (r_item.opcode == OP_SHUT) r_started <= 1'b0;
                            r_state <= (r_emit || r_pend_v) ? S_FLUSH : S_IDLE;
                        end else begin
                            r_idx <= r_idx + PW'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!o_out_valid || i_out_ready) begin
                        ob = r_pend;
                        ob.last = 1'b1;
                        o_out <= ob;
                        ov = 1'b1;
                        r_pend_v <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            o_out_valid <= ov;
        end
    end
endmodule
`default_nettype wire

// ===== design/plp_checker.sv =====
// port level checks for the peer liveness prober, bound to the top level
// depends on plp_pkg and peer_liveness_prober
`default_nettype none
module plp_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_in_ready,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire plp_pkg::t_out_item o_out
);
    import plp_pkg::*;
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result item changed while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("item accepted with result pending");
    a_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.action == ACT_PONG |-> o_out.last)
        else $error("pong result not last");
    a_bye_nonce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.action == ACT_BYE |-> o_out.out_nonce == 64'd0)
        else $error("goodbye with nonce");
endmodule

bind peer_liveness_prober plp_checker u_plp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
);
`default_nettype wire
